// ===== rtl/tdac_pkg.sv =====
// Shared types, constants and divide-by-constant helpers for the time-of-day
// adjust clock. No dependencies; every other file of the block imports it.
package tdac_pkg;

  localparam int unsigned AMOUNT_BITS_DEF = 16;
  localparam int unsigned HOURS_PER_DAY   = 24;
  localparam int unsigned MINS_PER_HOUR   = 60;
  localparam int unsigned HALF_DAY_HOURS  = 12;

  localparam logic [31:0] RECIP_60 = 32'((64'd1 << 32) / 64'(MINS_PER_HOUR));
  localparam logic [31:0] RECIP_24 = 32'((64'd1 << 32) / 64'(HOURS_PER_DAY));

  typedef enum logic [3:0] {
    OP_READ    = 4'd0,
    OP_SET_ALL = 4'd1,
    OP_SET_HR  = 4'd2,
    OP_SET_MIN = 4'd3,
    OP_SET_SEC = 4'd4,
    OP_ADD_SEC = 4'd5,
    OP_ADD_MIN = 4'd6,
    OP_ADD_HR  = 4'd7,
    OP_SUB_SEC = 4'd8,
    OP_SUB_MIN = 4'd9,
    OP_SUB_HR  = 4'd10
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] hours_value;
    logic [5:0] minutes_value;
    logic [5:0] seconds_value;
  } cmd_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } delta_t;

  typedef struct packed {
    cmd_t   cmd;
    delta_t delta;
  } item_t;

  typedef struct packed {
    logic [31:0] quot;
    logic [5:0]  rem;
  } divmod60_t;

  // The reciprocal estimate is at most one below the true quotient.
  function automatic divmod60_t div_mod_60(input logic [31:0] x);
    logic [63:0] prod;
    logic [31:0] q;
    logic [31:0] r;
    divmod60_t   res;
    prod = 64'(x) * 64'(RECIP_60);
    q = prod[63:32];
    r = x - ((q << 6) - (q << 2));
    if (r >= 32'(MINS_PER_HOUR)) begin
      q = q + 32'd1;
      r = r - 32'(MINS_PER_HOUR);
    end
    res.quot = q;
    res.rem  = r[5:0];
    return res;
  endfunction

  function automatic logic [4:0] mod_24(input logic [31:0] x);
    logic [63:0] prod;
    logic [31:0] q;
    logic [31:0] r;
    prod = 64'(x) * 64'(RECIP_24);
    q = prod[63:32];
    r = x - ((q << 4) + (q << 3));
    if (r >= 32'(HOURS_PER_DAY)) begin
      r = r - 32'(HOURS_PER_DAY);
    end
    return r[4:0];
  endfunction

endpackage

// ===== rtl/tdac_split.sv =====
// Three-stage pipeline that reduces an adjust amount to an hours, minutes and
// seconds offset within one day. Depends on tdac_pkg.
module tdac_split
  import tdac_pkg::*;
#(
  parameter int unsigned AMOUNT_BITS = AMOUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  cmd_t                   cmd_i,
  input  logic [AMOUNT_BITS-1:0] amount_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output item_t                  item_o
);

  localparam int unsigned Q1_W = AMOUNT_BITS - 5;
  localparam int unsigned Q2_W = (AMOUNT_BITS > 11) ? AMOUNT_BITS - 10 : 1;

  logic                   s1_valid_q;
  cmd_t                   s1_cmd_q;
  logic [AMOUNT_BITS-1:0] s1_amt_q;
  logic [Q1_W-1:0]        s1_q1_q;
  logic [5:0]             s1_r1_q;

  logic                   s2_valid_q;
  cmd_t                   s2_cmd_q;
  logic [AMOUNT_BITS-1:0] s2_amt_q;
  logic [Q1_W-1:0]        s2_q1_q;
  logic [5:0]             s2_r1_q;
  logic [Q2_W-1:0]        s2_q2_q;
  logic [5:0]             s2_r2_q;

  logic                   s3_valid_q;
  cmd_t                   s3_cmd_q;
  delta_t                 s3_delta_q;

  logic                   s1_ready;
  logic                   s2_ready;
  logic                   s3_ready;
  divmod60_t              dm1;
  divmod60_t              dm2;
  logic [31:0]            mod_src;
  logic [4:0]             h24;
  delta_t                 delta_d;

  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign dm1 = div_mod_60(32'(amount_i));
  assign dm2 = div_mod_60(32'(s1_q1_q));
  assign h24 = mod_24(mod_src);

  always_comb begin
    mod_src = 32'(s2_amt_q);
    delta_d = '0;
    case (s2_cmd_q.op)
      OP_ADD_SEC, OP_SUB_SEC: begin
        mod_src         = 32'(s2_q2_q);
        delta_d.seconds = s2_r1_q;
        delta_d.minutes = s2_r2_q;
        delta_d.hours   = h24;
      end
      OP_ADD_MIN, OP_SUB_MIN: begin
        mod_src         = 32'(s2_q1_q);
        delta_d.minutes = s2_r1_q;
        delta_d.hours   = h24;
      end
      OP_ADD_HR, OP_SUB_HR: begin
        delta_d.hours = h24;
      end
      default: begin
        delta_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_cmd_q <= cmd_i;
      s1_amt_q <= amount_i;
      s1_q1_q  <= dm1.quot[Q1_W-1:0];
      s1_r1_q  <= dm1.rem;
    end
    if (s1_valid_q && s2_ready) begin
      s2_cmd_q <= s1_cmd_q;
      s2_amt_q <= s1_amt_q;
      s2_q1_q  <= s1_q1_q;
      s2_r1_q  <= s1_r1_q;
      s2_q2_q  <= dm2.quot[Q2_W-1:0];
      s2_r2_q  <= dm2.rem;
    end
    if (s2_valid_q && s3_ready) begin
      s3_cmd_q   <= s2_cmd_q;
      s3_delta_q <= delta_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign item_o      = '{cmd: s3_cmd_q, delta: s3_delta_q};

endmodule

// ===== rtl/tdac_update.sv =====
// Time-of-day state registers and result register: applies set, add and
// subtract commands field by field with carry and borrow. Depends on tdac_pkg.
module tdac_update
  import tdac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  item_t      item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [4:0] hours_now_o,
  output logic [5:0] minutes_now_o,
  output logic [5:0] seconds_now_o,
  output logic [3:0] hour_twelve_o,
  output logic       is_pm_o,
  output logic       applied_o
);

  logic [4:0] hour_q;
  logic [5:0] minute_q;
  logic [5:0] second_q;
  logic       out_valid_q;
  logic [4:0] res_hours_q;
  logic [5:0] res_minutes_q;
  logic [5:0] res_seconds_q;
  logic [3:0] res_twelve_q;
  logic       res_pm_q;
  logic       res_applied_q;

  logic [4:0] hour_d;
  logic [5:0] minute_d;
  logic [5:0] second_d;
  logic       applied_d;
  logic [3:0] twelve_d;
  logic       pm_d;
  logic [4:0] half_hour;
  logic       accept;
  logic       hok;
  logic       mok;
  logic       sok;

  logic [6:0] sec_sum;
  logic       sec_carry;
  logic [6:0] min_sum;
  logic       min_carry;
  logic [5:0] hr_sum;
  logic [5:0] sec_add;
  logic [5:0] min_add;
  logic [4:0] hr_add;

  logic       sec_borrow;
  logic [6:0] min_need;
  logic       min_borrow;
  logic [5:0] hr_need;
  logic       hr_borrow;
  logic [6:0] sec_diff;
  logic [6:0] min_diff;
  logic [5:0] hr_diff;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign hok = item_i.cmd.hours_value < 5'(HOURS_PER_DAY);
  assign mok = item_i.cmd.minutes_value < 6'(MINS_PER_HOUR);
  assign sok = item_i.cmd.seconds_value < 6'(MINS_PER_HOUR);

  always_comb begin
    sec_sum   = 7'(second_q) + 7'(item_i.delta.seconds);
    sec_carry = sec_sum >= 7'(MINS_PER_HOUR);
    sec_add   = sec_carry ? 6'(sec_sum - 7'(MINS_PER_HOUR)) : sec_sum[5:0];
    min_sum   = 7'(minute_q) + 7'(item_i.delta.minutes) + 7'(sec_carry);
    min_carry = min_sum >= 7'(MINS_PER_HOUR);
    min_add   = min_carry ? 6'(min_sum - 7'(MINS_PER_HOUR)) : min_sum[5:0];
    hr_sum    = 6'(hour_q) + 6'(item_i.delta.hours) + 6'(min_carry);
    hr_add    = (hr_sum >= 6'(HOURS_PER_DAY)) ? 5'(hr_sum - 6'(HOURS_PER_DAY)) : hr_sum[4:0];

    sec_borrow = second_q < item_i.delta.seconds;
    sec_diff   = 7'(second_q) + (sec_borrow ? 7'(MINS_PER_HOUR) : 7'd0)
                 - 7'(item_i.delta.seconds);
    min_need   = 7'(item_i.delta.minutes) + 7'(sec_borrow);
    min_borrow = 7'(minute_q) < min_need;
    min_diff   = 7'(minute_q) + (min_borrow ? 7'(MINS_PER_HOUR) : 7'd0) - min_need;
    hr_need    = 6'(item_i.delta.hours) + 6'(min_borrow);
    hr_borrow  = 6'(hour_q) < hr_need;
    hr_diff    = 6'(hour_q) + (hr_borrow ? 6'(HOURS_PER_DAY) : 6'd0) - hr_need;
  end

  always_comb begin
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    applied_d = 1'b1;
    case (item_i.cmd.op)
      OP_SET_ALL: begin
        if (hok && mok && sok) begin
          hour_d   = item_i.cmd.hours_value;
          minute_d = item_i.cmd.minutes_value;
          second_d = item_i.cmd.seconds_value;
        end else begin
          applied_d = 1'b0;
        end
      end
      OP_SET_HR: begin
        if (hok) begin
          hour_d = item_i.cmd.hours_value;
        end else begin
          applied_d = 1'b0;
        end
      end
      OP_SET_MIN: begin
        if (mok) begin
          minute_d = item_i.cmd.minutes_value;
        end else begin
          applied_d = 1'b0;
        end
      end
      OP_SET_SEC: begin
        if (sok) begin
          second_d = item_i.cmd.seconds_value;
        end else begin
          applied_d = 1'b0;
        end
      end
      OP_ADD_SEC, OP_ADD_MIN, OP_ADD_HR: begin
        hour_d   = hr_add;
        minute_d = min_add;
        second_d = sec_add;
      end
      OP_SUB_SEC, OP_SUB_MIN, OP_SUB_HR: begin
        hour_d   = hr_diff[4:0];
        minute_d = min_diff[5:0];
        second_d = sec_diff[5:0];
      end
      default: begin
        applied_d = 1'b1;
      end
    endcase
  end

  always_comb begin
    pm_d      = hour_d >= 5'(HALF_DAY_HOURS);
    half_hour = pm_d ? hour_d - 5'(HALF_DAY_HOURS) : hour_d;
    twelve_d  = (half_hour == 5'd0) ? 4'(HALF_DAY_HOURS) : half_hour[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q      <= '0;
      minute_q    <= '0;
      second_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        hour_q   <= hour_d;
        minute_q <= minute_d;
        second_q <= second_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_hours_q   <= hour_d;
      res_minutes_q <= minute_d;
      res_seconds_q <= second_d;
      res_twelve_q  <= twelve_d;
      res_pm_q      <= pm_d;
      res_applied_q <= applied_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hours_now_o   = res_hours_q;
  assign minutes_now_o = res_minutes_q;
  assign seconds_now_o = res_seconds_q;
  assign hour_twelve_o = res_twelve_q;
  assign is_pm_o       = res_pm_q;
  assign applied_o     = res_applied_q;

endmodule

// ===== rtl/time_of_day_adjust_clock_core.sv =====
// Top level of the time-of-day adjust clock: amount reduction pipeline and
// time state update. Depends on tdac_pkg, tdac_split and tdac_update.
//
// Usage: each input transaction carries one command (read, set all, set one
// field, or add or subtract an amount of seconds, minutes or hours). Every
// command produces exactly one output transaction with the time after the
// command, the 12-hour hour, a PM flag and whether a set was applied.
// Both channels use valid/ready; a transaction completes when both are high.
// Three stages reduce the amount to an offset within one day, and the
// last stage updates the time registers and loads the result register.
// Throughput is one command per cycle while the receiver does not stall;
// the time registers are read and written by the last stage only, so
// back-to-back commands see each other's effect in order.
// Reset clears the time to 00:00:00 and empties the pipeline.
// When the receiver stalls, the result register holds its transaction and
// the stages behind it keep filling; input ready drops only once every
// stage holds a command.
module time_of_day_adjust_clock_core
  import tdac_pkg::*;
#(
  parameter int unsigned AMOUNT_BITS = AMOUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [3:0]             operation_i,
  input  logic [4:0]             hours_value_i,
  input  logic [5:0]             minutes_value_i,
  input  logic [5:0]             seconds_value_i,
  input  logic [AMOUNT_BITS-1:0] amount_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [4:0]             hours_now_o,
  output logic [5:0]             minutes_now_o,
  output logic [5:0]             seconds_now_o,
  output logic [3:0]             hour_twelve_o,
  output logic                   is_pm_o,
  output logic                   applied_o
);

  cmd_t  cmd;
  item_t item;
  logic  item_valid;
  logic  item_ready;

  assign cmd = '{
    op:            op_e'(operation_i),
    hours_value:   hours_value_i,
    minutes_value: minutes_value_i,
    seconds_value: seconds_value_i
  };

  tdac_split #(
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd),
    .amount_i    (amount_i),
    .out_valid_o (item_valid),
    .out_ready_i (item_ready),
    .item_o      (item)
  );

  tdac_update u_update (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (item_valid),
    .in_ready_o    (item_ready),
    .item_i        (item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hours_now_o   (hours_now_o),
    .minutes_now_o (minutes_now_o),
    .seconds_now_o (seconds_now_o),
    .hour_twelve_o (hour_twelve_o),
    .is_pm_o       (is_pm_o),
    .applied_o     (applied_o)
  );

endmodule

// ===== rtl/tdac_checker.sv =====
// Port-level checks for the time-of-day adjust clock, bound to the top level.
// Depends on tdac_pkg and time_of_day_adjust_clock_core.
module tdac_checker
  import tdac_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [4:0] hours_now_o,
  input logic [5:0] minutes_now_o,
  input logic [5:0] seconds_now_o,
  input logic [3:0] hour_twelve_o,
  input logic       is_pm_o
);

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hours_now_o)
      && $stable(minutes_now_o) && $stable(seconds_now_o))
    else $error("Stalled result transaction changed.");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hours_now_o < 5'(HOURS_PER_DAY)
      && minutes_now_o < 6'(MINS_PER_HOUR) && seconds_now_o < 6'(MINS_PER_HOUR))
    else $error("Result time out of range.");

  a_pm_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_pm_o == (hours_now_o >= 5'(HALF_DAY_HOURS)))
    else $error("PM flag disagrees with hours.");

  a_twelve_hour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_twelve_o == 4'(HALF_DAY_HOURS)
      && (hours_now_o == 5'd0 || hours_now_o == 5'(HALF_DAY_HOURS)))
      || (5'(hour_twelve_o) == hours_now_o && !is_pm_o && hours_now_o != 5'd0)
      || (5'(hour_twelve_o) + 5'(HALF_DAY_HOURS) == hours_now_o && is_pm_o
          && hours_now_o != 5'(HALF_DAY_HOURS)))
    else $error("12-hour display disagrees with hours.");

endmodule

bind time_of_day_adjust_clock_core tdac_checker u_tdac_checker (.*);
